[rtl/vna_pkg.sv]
// Shared types and constants for the vertex normal averager.
// Used by the divider, the square root unit and the top level; depends on nothing.
`default_nettype none

package vna_pkg;

    // Item kinds on the input channel.
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_TRI   = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Unit length in Q1.14.
    localparam logic [15:0] ONE_Q14 = 16'd16384;

    // Iterative divider and square root widths.
    localparam int DIV_NW  = 48;
    localparam int DIV_DW  = 32;
    localparam int SQRT_W  = 64;
    localparam int SQRT_RW = 32;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

    typedef struct packed {
        logic              start;
        logic [SQRT_W-1:0] rad;
    } t_sqrt_req;

    typedef struct packed {
        logic               done;
        logic [SQRT_RW-1:0] root;
    } t_sqrt_rsp;

endpackage

`default_nettype wire

[rtl/vna_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on vna_pkg for its widths and request and response structs.
`default_nettype none

module vna_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vna_pkg::t_div_req i_req,
    output vna_pkg::t_div_rsp      o_rsp
);

    localparam int NW = vna_pkg::DIV_NW;
    localparam int DW = vna_pkg::DIV_DW;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [NW-1:0] r_quo;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          take;

    // The quotient register starts out holding the dividend and shifts it out.
    assign rem_sh  = {r_rem, r_quo[NW-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign take    = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.den;
            r_quo <= i_req.num;
        end else if (r_busy) begin
            r_rem <= take ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            r_quo <= {r_quo[NW-2:0], take};
        end
    end

    assign o_rsp = '{done: r_done, quo: r_quo};

endmodule

`default_nettype wire

[rtl/vna_sqrt.sv]
// Digit-by-digit floor integer square root, one result bit per cycle.
// Depends on vna_pkg for its widths and request and response structs.
`default_nettype none

module vna_sqrt (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire vna_pkg::t_sqrt_req i_req,
    output vna_pkg::t_sqrt_rsp      o_rsp
);

    localparam int W  = vna_pkg::SQRT_W;
    localparam int RW = vna_pkg::SQRT_RW;
    localparam int CW = $clog2(RW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rad;
    logic [RW+1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [RW+3:0] rem_sh;
    logic [RW+3:0] trial;
    logic [RW+3:0] rem_dif;
    logic          take;

    // The remainder never exceeds twice the partial root.
    assign rem_sh  = {r_rem, r_rad[W-1:W-2]};
    assign trial   = {2'b00, r_root, 2'b01};
    assign rem_dif = rem_sh - trial;
    assign take    = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CW'(RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rad  <= i_req.rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[W-3:0], 2'b00};
            r_rem  <= take ? rem_dif[RW+1:0] : rem_sh[RW+1:0];
            r_root <= {r_root[RW-2:0], take};
        end
    end

    assign o_rsp = '{done: r_done, root: r_root};

endmodule

`default_nettype wire

[rtl/vertex_normal_averager.sv]
// Vertex normal averager: position, mean normal and count stores, a sequencer, one shared
// 33x33 multiplier, an iterative divider (vna_div) and square root unit (vna_sqrt); uses vna_pkg.
// Load: never stalls the input. Query: input stalled in S_QRD and S_QWAIT, plus any wait for the
// result slot. Triangle: input stalled through position reads, the cross product, N <= 30
// normalizing shifts, a square root, three divides, then per corner a three-divide fold (none
// on a first contribution). After reset: count store cleared one entry a cycle, input stalled.
`default_nettype none

module vertex_normal_averager #(
    parameter int VERTEX_SLOTS = 1024
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    // Input channel.
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [1:0]         i_kind,
    input  wire logic [9:0]         i_vertex_index,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    input  wire logic signed [15:0] i_pos_z,
    input  wire logic [9:0]         i_tri_a,
    input  wire logic [9:0]         i_tri_b,
    input  wire logic [9:0]         i_tri_c,

    // Result channel.
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [9:0]              o_queried_index,
    output logic signed [15:0]      o_normal_x,
    output logic signed [15:0]      o_normal_y,
    output logic signed [15:0]      o_normal_z,
    output logic                    o_has_normal
);

    localparam int AW = $clog2(VERTEX_SLOTS);

    // Sequencer states.
    localparam logic [4:0] S_CLEAR = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_QRD   = 5'd2;
    localparam logic [4:0] S_QWAIT = 5'd3;
    localparam logic [4:0] S_TRA   = 5'd4;
    localparam logic [4:0] S_TRB   = 5'd5;
    localparam logic [4:0] S_TRC   = 5'd6;
    localparam logic [4:0] S_TUW   = 5'd7;
    localparam logic [4:0] S_TMUL  = 5'd8;
    localparam logic [4:0] S_TMAG  = 5'd9;
    localparam logic [4:0] S_TNORM = 5'd10;
    localparam logic [4:0] S_TSQ   = 5'd11;
    localparam logic [4:0] S_TSQRT = 5'd12;
    localparam logic [4:0] S_TSQW  = 5'd13;
    localparam logic [4:0] S_TDIV  = 5'd14;
    localparam logic [4:0] S_TDIVW = 5'd15;
    localparam logic [4:0] S_FRD   = 5'd16;
    localparam logic [4:0] S_FCHK  = 5'd17;
    localparam logic [4:0] S_FMUL  = 5'd18;
    localparam logic [4:0] S_FNUM  = 5'd19;
    localparam logic [4:0] S_FDIV  = 5'd20;
    localparam logic [4:0] S_FDIVW = 5'd21;
    localparam logic [4:0] S_FWR   = 5'd22;

    function automatic logic [AW-1:0] to_addr(input logic [9:0] v);
        return AW'({{AW{1'b0}}, v});
    endfunction

    function automatic logic in_rng(input logic [9:0] v);
        return ({22'b0, v} < 32'(VERTEX_SLOTS));
    endfunction

    // Control registers.
    logic [4:0]    r_state;
    logic [AW-1:0] r_clr;
    logic          r_out_valid;

    // Item and datapath registers.
    logic [9:0]         r_idx;
    logic               r_in_rng;
    logic [AW-1:0]      r_tri [3];
    logic signed [15:0] r_pa [3];
    logic signed [15:0] r_pb [3];
    logic signed [16:0] r_u [3];
    logic signed [16:0] r_w [3];
    logic [2:0]         r_step;
    logic signed [65:0] r_prod;
    logic signed [34:0] r_cr [3];
    logic [2:0]         r_neg;
    logic [33:0]        r_mag [3];
    logic [63:0]        r_sum;
    logic [31:0]        r_len;
    logic [1:0]         r_comp;
    logic signed [15:0] r_nrm [3];
    logic [1:0]         r_corner;
    logic [7:0]         r_cnt_val;
    logic signed [25:0] r_fnum;
    logic signed [15:0] r_newm [3];

    // Output registers.
    logic [9:0]         r_out_idx;
    logic signed [15:0] r_out_nx;
    logic signed [15:0] r_out_ny;
    logic signed [15:0] r_out_nz;
    logic               r_out_has;

    // Stores and their registered read data.
    logic [47:0] pos_mem  [VERTEX_SLOTS];
    logic [47:0] mean_mem [VERTEX_SLOTS];
    logic [7:0]  cnt_mem  [VERTEX_SLOTS];
    logic [47:0] r_pos_rd;
    logic [47:0] r_mean_rd;
    logic [7:0]  r_cnt_rd;

    logic          pos_we;
    logic          pos_re;
    logic [AW-1:0] pos_ra;
    logic          nc_re;
    logic [AW-1:0] nc_ra;
    logic          cnt_we;
    logic [AW-1:0] cnt_wa;
    logic [7:0]    cnt_wd;
    logic          mean_we;
    logic [47:0]   mean_wd;

    logic                 accept;
    logic                 slot_free;
    logic signed [32:0]   mul_a;
    logic signed [32:0]   mul_b;
    logic signed [34:0]   prod_lo;
    logic [33:0]          mag_or;
    logic [15:0]          q_clamp;
    logic signed [15:0]   mean_cur;
    logic [25:0]          fabs;
    logic [8:0]           fden;
    logic [7:0]           cnt_next;

    vna_pkg::t_div_req  div_req;
    vna_pkg::t_div_rsp  div_rsp;
    vna_pkg::t_sqrt_req sqrt_req;
    vna_pkg::t_sqrt_rsp sqrt_rsp;

    assign o_stall   = (r_state != S_IDLE);
    assign accept    = i_valid && !o_stall;
    assign slot_free = !r_out_valid || !i_stall;

    assign prod_lo  = $signed(r_prod[34:0]);
    assign mag_or   = r_mag[0] | r_mag[1] | r_mag[2];
    assign mean_cur = $signed(r_mean_rd[16*r_comp +: 16]);
    assign fabs     = r_fnum[25] ? 26'(-r_fnum) : 26'(r_fnum);
    assign fden     = {1'b0, r_cnt_val} + 9'd1;
    assign cnt_next = (r_cnt_val == 8'd255) ? 8'd255 : r_cnt_val + 8'd1;
    // A component cannot exceed one, but the rounding is clamped to be safe.
    assign q_clamp  = (div_rsp.quo > 48'(vna_pkg::ONE_Q14)) ? vna_pkg::ONE_Q14
                                                           : div_rsp.quo[15:0];

    // Shared multiplier operands: cross product terms, squared magnitudes, mean times count.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_TMUL: begin
                unique case (r_step)
                    3'd0: begin mul_a = 33'(r_u[1]); mul_b = 33'(r_w[2]); end
                    3'd1: begin mul_a = 33'(r_u[2]); mul_b = 33'(r_w[1]); end
                    3'd2: begin mul_a = 33'(r_u[2]); mul_b = 33'(r_w[0]); end
                    3'd3: begin mul_a = 33'(r_u[0]); mul_b = 33'(r_w[2]); end
                    3'd4: begin mul_a = 33'(r_u[0]); mul_b = 33'(r_w[1]); end
                    3'd5: begin mul_a = 33'(r_u[1]); mul_b = 33'(r_w[0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            S_TSQ: begin
                if (r_step < 3'd3) begin
                    mul_a = {2'b00, r_mag[r_step[1:0]][30:0]};
                    mul_b = {2'b00, r_mag[r_step[1:0]][30:0]};
                end
            end
            S_FMUL: begin
                mul_a = 33'(mean_cur);
                mul_b = {25'b0, r_cnt_val};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Store port control.
    always_comb begin
        pos_we  = accept && (i_kind == vna_pkg::KIND_LOAD) && in_rng(i_vertex_index);
        pos_re  = 1'b0;
        pos_ra  = r_tri[0];
        nc_re   = 1'b0;
        nc_ra   = r_tri[r_corner];
        cnt_we  = 1'b0;
        cnt_wa  = r_tri[r_corner];
        cnt_wd  = cnt_next;
        mean_we = 1'b0;
        mean_wd = {r_newm[2], r_newm[1], r_newm[0]};
        unique case (r_state)
            S_CLEAR: begin
                cnt_we = 1'b1;
                cnt_wa = r_clr;
                cnt_wd = '0;
            end
            S_QRD: begin
                nc_re = 1'b1;
                nc_ra = to_addr(r_idx);
            end
            S_TRA: begin
                pos_re = 1'b1;
                pos_ra = r_tri[0];
            end
            S_TRB: begin
                pos_re = 1'b1;
                pos_ra = r_tri[1];
            end
            S_TRC: begin
                pos_re = 1'b1;
                pos_ra = r_tri[2];
            end
            S_FRD: begin
                nc_re = 1'b1;
            end
            S_FCHK: begin
                // First contribution: the normal itself becomes the mean.
                if (r_cnt_rd == 8'd0) begin
                    cnt_we  = 1'b1;
                    cnt_wd  = 8'd1;
                    mean_we = 1'b1;
                    mean_wd = {r_nrm[2], r_nrm[1], r_nrm[0]};
                end
            end
            S_FWR: begin
                cnt_we  = 1'b1;
                mean_we = 1'b1;
            end
            default: begin
                pos_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[to_addr(i_vertex_index)] <= {i_pos_z, i_pos_y, i_pos_x};
        end
        if (pos_re) begin
            r_pos_rd <= pos_mem[pos_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mean_we) begin
            mean_mem[cnt_wa] <= mean_wd;
        end
        if (nc_re) begin
            r_mean_rd <= mean_mem[nc_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (nc_re) begin
            r_cnt_rd <= cnt_mem[nc_ra];
        end
    end

    // Divider and square root requests.
    always_comb begin
        div_req.start = (r_state == S_TDIV) || (r_state == S_FDIV);
        if (r_state == S_FDIV) begin
            div_req.num = {22'b0, fabs} + {40'b0, fden[8:1]};
            div_req.den = {23'b0, fden};
        end else begin
            div_req.num = {3'b0, r_mag[r_comp][30:0], 14'b0} + {17'b0, r_len[31:1]};
            div_req.den = r_len;
        end
        sqrt_req.start = (r_state == S_TSQRT);
        sqrt_req.rad   = r_sum;
    end

    vna_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    vna_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_rsp   (sqrt_rsp)
    );

    // Sequencer and datapath. Only the state, the clear counter and the output valid
    // are reset; everything else is payload loaded before it is used.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_QWAIT && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == AW'(VERTEX_SLOTS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (accept && i_kind == vna_pkg::KIND_QUERY) begin
                        r_idx    <= i_vertex_index;
                        r_in_rng <= in_rng(i_vertex_index);
                        r_state  <= S_QRD;
                    end else if (accept && i_kind == vna_pkg::KIND_TRI) begin
                        // A triangle with any corner out of range is dropped whole.
                        if (in_rng(i_tri_a) && in_rng(i_tri_b) && in_rng(i_tri_c)) begin
                            r_tri[0] <= to_addr(i_tri_a);
                            r_tri[1] <= to_addr(i_tri_b);
                            r_tri[2] <= to_addr(i_tri_c);
                            r_state  <= S_TRA;
                        end
                    end
                end

                S_QRD: begin
                    r_state <= S_QWAIT;
                end

                S_QWAIT: begin
                    if (slot_free) begin
                        r_out_idx <= r_idx;
                        if (r_in_rng && r_cnt_rd != 8'd0) begin
                            r_out_nx  <= $signed(r_mean_rd[15:0]);
                            r_out_ny  <= $signed(r_mean_rd[31:16]);
                            r_out_nz  <= $signed(r_mean_rd[47:32]);
                            r_out_has <= 1'b1;
                        end else begin
                            r_out_nx  <= '0;
                            r_out_ny  <= '0;
                            r_out_nz  <= '0;
                            r_out_has <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end

                S_TRA: begin
                    r_state <= S_TRB;
                end

                S_TRB: begin
                    for (int i = 0; i < 3; i++) begin
                        r_pa[i] <= $signed(r_pos_rd[16*i +: 16]);
                    end
                    r_state <= S_TRC;
                end

                S_TRC: begin
                    for (int i = 0; i < 3; i++) begin
                        r_pb[i] <= $signed(r_pos_rd[16*i +: 16]);
                    end
                    r_state <= S_TUW;
                end

                S_TUW: begin
                    // Edge vectors c - a and b - a.
                    for (int i = 0; i < 3; i++) begin
                        r_u[i] <= {r_pos_rd[16*i+15], r_pos_rd[16*i +: 16]}
                                  - {r_pa[i][15], r_pa[i]};
                        r_w[i] <= {r_pb[i][15], r_pb[i]} - {r_pa[i][15], r_pa[i]};
                    end
                    r_step  <= '0;
                    r_state <= S_TMUL;
                end

                S_TMUL: begin
                    // Product k is registered and taken up at step k + 1; pairs are subtracted.
                    r_step <= r_step + 3'd1;
                    unique case (r_step)
                        3'd0: r_cr[0] <= r_cr[0];
                        3'd1: r_cr[0] <= prod_lo;
                        3'd2: r_cr[0] <= r_cr[0] - prod_lo;
                        3'd3: r_cr[1] <= prod_lo;
                        3'd4: r_cr[1] <= r_cr[1] - prod_lo;
                        3'd5: r_cr[2] <= prod_lo;
                        3'd6: begin
                            r_cr[2] <= r_cr[2] - prod_lo;
                            r_state <= S_TMAG;
                        end
                        default: r_state <= S_TMAG;
                    endcase
                end

                S_TMAG: begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= r_cr[i][34] ? 34'(-r_cr[i]) : 34'(r_cr[i]);
                        r_neg[i] <= r_cr[i][34];
                    end
                    if (r_cr[0] == '0 && r_cr[1] == '0 && r_cr[2] == '0) begin
                        // Degenerate triangle: zero normal, still folded in.
                        for (int i = 0; i < 3; i++) begin
                            r_nrm[i] <= '0;
                        end
                        r_corner <= '0;
                        r_state  <= S_FRD;
                    end else begin
                        r_state <= S_TNORM;
                    end
                end

                S_TNORM: begin
                    // One bit of shift a cycle until the largest magnitude tops out at bit 30.
                    if (|mag_or[33:31]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= {1'b0, r_mag[i][33:1]};
                        end
                    end else if (!mag_or[30]) begin
                        for (int i = 0; i < 3; i++) begin
                            r_mag[i] <= {r_mag[i][32:0], 1'b0};
                        end
                    end else begin
                        r_step  <= '0;
                        r_sum   <= '0;
                        r_state <= S_TSQ;
                    end
                end

                S_TSQ: begin
                    r_step <= r_step + 3'd1;
                    if (r_step != 3'd0) begin
                        r_sum <= r_sum + r_prod[63:0];
                    end
                    if (r_step == 3'd3) begin
                        r_state <= S_TSQRT;
                    end
                end

                S_TSQRT: begin
                    r_state <= S_TSQW;
                end

                S_TSQW: begin
                    if (sqrt_rsp.done) begin
                        r_len   <= sqrt_rsp.root;
                        r_comp  <= '0;
                        r_state <= S_TDIV;
                    end
                end

                S_TDIV: begin
                    r_state <= S_TDIVW;
                end

                S_TDIVW: begin
                    if (div_rsp.done) begin
                        r_nrm[r_comp] <= r_neg[r_comp] ? $signed(-q_clamp) : $signed(q_clamp);
                        if (r_comp == 2'd2) begin
                            r_corner <= '0;
                            r_state  <= S_FRD;
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_state <= S_TDIV;
                        end
                    end
                end

                S_FRD: begin
                    r_state <= S_FCHK;
                end

                S_FCHK: begin
                    r_cnt_val <= r_cnt_rd;
                    if (r_cnt_rd == 8'd0) begin
                        if (r_corner == 2'd2) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_corner <= r_corner + 2'd1;
                            r_state  <= S_FRD;
                        end
                    end else begin
                        r_comp  <= '0;
                        r_state <= S_FMUL;
                    end
                end

                S_FMUL: begin
                    r_state <= S_FNUM;
                end

                S_FNUM: begin
                    r_fnum  <= $signed(r_prod[25:0]) + 26'(r_nrm[r_comp]);
                    r_state <= S_FDIV;
                end

                S_FDIV: begin
                    r_state <= S_FDIVW;
                end

                S_FDIVW: begin
                    if (div_rsp.done) begin
                        // Rounded half away from zero: divide the magnitude, restore the sign.
                        r_newm[r_comp] <= r_fnum[25] ? $signed(-div_rsp.quo[15:0])
                                                     : $signed(div_rsp.quo[15:0]);
                        if (r_comp == 2'd2) begin
                            r_state <= S_FWR;
                        end else begin
                            r_comp  <= r_comp + 2'd1;
                            r_state <= S_FMUL;
                        end
                    end
                end

                S_FWR: begin
                    if (r_corner == 2'd2) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_corner <= r_corner + 2'd1;
                        r_state  <= S_FRD;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_queried_index = r_out_idx;
    assign o_normal_x      = r_out_nx;
    assign o_normal_y      = r_out_ny;
    assign o_normal_z      = r_out_nz;
    assign o_has_normal    = r_out_has;

`ifndef SYNTHESIS
    // A result beat only ever comes out of the query read path.
    a_out_from_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state) == S_QWAIT)
        else $error("result beat appeared without a query");

    // A vertex without a normal answers with a zero vector.
    a_zero_without_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_has_normal) |->
            (o_normal_x == 16'sd0 && o_normal_y == 16'sd0 && o_normal_z == 16'sd0))
        else $error("nonzero normal reported for vertex without contributions");

    // A mean of unit normals never leaves the unit range.
    a_normal_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_normal_x >= -16'sd16384 && o_normal_x <= 16'sd16384 &&
                     o_normal_y >= -16'sd16384 && o_normal_y <= 16'sd16384 &&
                     o_normal_z >= -16'sd16384 && o_normal_z <= 16'sd16384))
        else $error("mean normal component out of range");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_TDIVW || r_state == S_FDIVW))
        else $error("divider finished outside a wait state");
`endif

endmodule

`default_nettype wire

[test/tb_vertex_normal_averager.sv]
// Self-checking testbench for vertex_normal_averager: directed table, count saturation
// burst and random mesh traffic, scored against this file's predictor or typed answers.
// Depends on rtl/vna_pkg.sv and rtl/vertex_normal_averager.sv.
`timescale 1ns / 1ps

module tb_vertex_normal_averager;

    // Kind 3 is unused by the block and must be swallowed without a result.
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int SLOTS        = 1024;
    localparam int RANDOM_ITEMS = 1460;
    localparam int HOLD_CYCLES  = 3000;
    localparam int DRAIN_CYCLES = 1000;
    // This covers every item being a triangle, each stalling the input its longest,
    // behind the worst sender gaps and receiver stalls several times over.
    localparam longint CYCLE_LIMIT = 64'd8_000_000;

    typedef struct {
        logic [1:0]         kind;
        logic [9:0]         vidx;
        logic signed [15:0] px, py, pz;
        logic [9:0]         ta, tb, tc;
    } t_mesh_beat;

    typedef struct {
        logic [9:0]         idx;
        logic signed [15:0] nx, ny, nz;
        logic               has;
    } t_normal_answer;

    typedef struct {
        t_mesh_beat     beat;
        bit             typed;
        t_normal_answer answer;
    } t_table_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_kind = vna_pkg::KIND_LOAD;
    logic [9:0]         i_vertex_index = '0;
    logic signed [15:0] i_pos_x = '0;
    logic signed [15:0] i_pos_y = '0;
    logic signed [15:0] i_pos_z = '0;
    logic [9:0]         i_tri_a = '0;
    logic [9:0]         i_tri_b = '0;
    logic [9:0]         i_tri_c = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [9:0]         o_queried_index;
    logic signed [15:0] o_normal_x;
    logic signed [15:0] o_normal_y;
    logic signed [15:0] o_normal_z;
    logic               o_has_normal;

    vertex_normal_averager #(.VERTEX_SLOTS(SLOTS)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_kind(i_kind),
        .i_vertex_index(i_vertex_index),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_tri_a(i_tri_a), .i_tri_b(i_tri_b), .i_tri_c(i_tri_c),
        .o_valid(o_valid), .i_stall(i_stall), .o_queried_index(o_queried_index),
        .o_normal_x(o_normal_x), .o_normal_y(o_normal_y), .o_normal_z(o_normal_z),
        .o_has_normal(o_has_normal)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Predictor state: its own copy of the three stores.
    logic signed [15:0] pos_mirror  [SLOTS][3];
    logic signed [15:0] mean_mirror [SLOTS][3];
    int unsigned        count_mirror[SLOTS];
    bit                 was_loaded  [SLOTS];
    int                 loaded_list[$];

    t_normal_answer pending_answers[$];
    t_table_row     stimulus_table[$];
    int  fault_count = 0;
    int  tx_idle_pct = 28;
    int  rx_idle_pct = 62;
    logic hold_req = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_cnt = 0;
    longint cycle_cnt = 0;

    // Floor square root, one result bit per pass.
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'h1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Unit normal of cross(c - a, b - a), Q1.14, zero for a degenerate face.
    task automatic face_normal(input logic [9:0] a, input logic [9:0] b, input logic [9:0] c,
                               output longint nrm[3]);
        longint u[3], w[3], cr[3];
        logic [63:0] mag[3], m, sum, len, q;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            u[i] = longint'(pos_mirror[c][i]) - longint'(pos_mirror[a][i]);
            w[i] = longint'(pos_mirror[b][i]) - longint'(pos_mirror[a][i]);
        end
        cr[0] = u[1] * w[2] - u[2] * w[1];
        cr[1] = u[2] * w[0] - u[0] * w[2];
        cr[2] = u[0] * w[1] - u[1] * w[0];
        for (int i = 0; i < 3; i++) begin
            mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
            if (mag[i] > m) m = mag[i];
            nrm[i] = 0;
        end
        if (m != 0) begin
            // Normalize so the largest magnitude has its top bit at bit 30.
            while (m >= (64'h1 << 31)) begin
                m = m >> 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
            end
            while (m < (64'h1 << 30)) begin
                m = m << 1;
                for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
            end
            sum = 0;
            for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
            len = floor_root(sum);
            for (int i = 0; i < 3; i++) begin
                q = (mag[i] * 16384 + len / 2) / len;
                if (q > 16384) q = 16384;
                nrm[i] = cr[i] < 0 ? -longint'(q) : longint'(q);
            end
        end
    endtask

    // Fold one normal into a vertex's running mean; the count saturates at 255.
    task automatic fold_into_mean(input logic [9:0] v, input longint nrm[3]);
        longint num, den, mag, q;
        if (count_mirror[v] == 0) begin
            for (int i = 0; i < 3; i++) mean_mirror[v][i] = 16'(nrm[i]);
            count_mirror[v] = 1;
        end else begin
            for (int i = 0; i < 3; i++) begin
                num = longint'(mean_mirror[v][i]) * longint'(count_mirror[v]) + nrm[i];
                den = longint'(count_mirror[v]) + 1;
                mag = num < 0 ? -num : num;
                q = (mag + den / 2) / den;
                mean_mirror[v][i] = 16'(num < 0 ? -q : q);
            end
            if (count_mirror[v] < 255) count_mirror[v] = count_mirror[v] + 1;
        end
    endtask

    // Advances the mirrored stores for one accepted beat; a query yields an answer.
    task automatic mirror_beat(input t_mesh_beat bt, output bit answers,
                               output t_normal_answer ans);
        longint nrm[3];
        answers = 0;
        ans = '{default: '0};
        case (bt.kind)
            vna_pkg::KIND_LOAD: begin
                pos_mirror[bt.vidx][0] = bt.px;
                pos_mirror[bt.vidx][1] = bt.py;
                pos_mirror[bt.vidx][2] = bt.pz;
                if (!was_loaded[bt.vidx]) begin
                    was_loaded[bt.vidx] = 1;
                    loaded_list = {loaded_list, int'(bt.vidx)};
                end
            end
            vna_pkg::KIND_TRI: begin
                face_normal(bt.ta, bt.tb, bt.tc, nrm);
                fold_into_mean(bt.ta, nrm);
                fold_into_mean(bt.tb, nrm);
                fold_into_mean(bt.tc, nrm);
            end
            vna_pkg::KIND_QUERY: begin
                answers = 1;
                ans.idx = bt.vidx;
                ans.has = count_mirror[bt.vidx] != 0;
                if (ans.has) begin
                    ans.nx = mean_mirror[bt.vidx][0];
                    ans.ny = mean_mirror[bt.vidx][1];
                    ans.nz = mean_mirror[bt.vidx][2];
                end
            end
            default: ;
        endcase
    endtask

    // Offers one beat, holding it until accepted, then records what it should produce.
    task automatic offer_beat(input t_mesh_beat bt, input bit typed, input t_normal_answer want);
        bit answers;
        t_normal_answer pred;
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_kind         <= bt.kind;
        i_vertex_index <= bt.vidx;
        i_pos_x        <= bt.px;
        i_pos_y        <= bt.py;
        i_pos_z        <= bt.pz;
        i_tri_a        <= bt.ta;
        i_tri_b        <= bt.tb;
        i_tri_c        <= bt.tc;
        i_valid        <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        mirror_beat(bt, answers, pred);
        if (typed) pred = want;
        if (answers) pending_answers = {pending_answers, pred};
    endtask

    function automatic t_mesh_beat make_beat(input logic [1:0] kind, input int vidx,
                                             input int px, input int py, input int pz,
                                             input int a, input int b, input int c);
        t_mesh_beat bt;
        bt.kind = kind;
        bt.vidx = 10'(vidx);
        bt.px = 16'(px);
        bt.py = 16'(py);
        bt.pz = 16'(pz);
        bt.ta = 10'(a);
        bt.tb = 10'(b);
        bt.tc = 10'(c);
        return bt;
    endfunction

    function automatic t_mesh_beat noise_beat(input logic [1:0] kind);
        t_mesh_beat bt;
        bt.kind = kind;
        bt.vidx = 10'($urandom);
        bt.px = 16'($urandom);
        bt.py = 16'($urandom);
        bt.pz = 16'($urandom);
        bt.ta = 10'($urandom);
        bt.tb = 10'($urandom);
        bt.tc = 10'($urandom);
        return bt;
    endfunction

    task automatic add_row(input logic [1:0] kind, input int vidx, input int px, input int py,
                           input int pz, input int a, input int b, input int c,
                           input bit typed, input int nx, input int ny, input int nz,
                           input bit has);
        t_table_row row;
        row.beat = make_beat(kind, vidx, px, py, pz, a, b, c);
        row.typed = typed;
        row.answer.idx = 10'(vidx);
        row.answer.nx = 16'(nx);
        row.answer.ny = 16'(ny);
        row.answer.nz = 16'(nz);
        row.answer.has = has;
        stimulus_table = {stimulus_table, row};
    endtask

    // A loaded vertex, often from the first few loaded so that counts climb.
    function automatic logic [9:0] pick_corner();
        int span;
        span = loaded_list.size();
        if (span > 16 && $urandom_range(0, 1)) span = 16;
        return 10'(loaded_list[$urandom_range(0, span - 1)]);
    endfunction

    function automatic logic signed [15:0] pick_coord();
        if ($urandom_range(0, 4) == 0) return 16'($signed($urandom_range(0, 8)) - 4);
        return 16'($urandom);
    endfunction

    // Result side: score every accepted result beat, then pick the next stall.
    always @(posedge i_clk) begin
        t_normal_answer exp_ans;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_answers.size() == 0) begin
                fault_count = fault_count + 1;
                if (fault_count <= 10)
                    $display("unexpected result beat: index %0d", o_queried_index);
            end else begin
                exp_ans = pending_answers.pop_front();
                if (o_queried_index !== exp_ans.idx || o_normal_x !== exp_ans.nx ||
                    o_normal_y !== exp_ans.ny || o_normal_z !== exp_ans.nz ||
                    o_has_normal !== exp_ans.has) begin
                    fault_count = fault_count + 1;
                    if (fault_count <= 10)
                        $display({"mismatch: expected idx %0d n (%0d %0d %0d) has %0d,",
                                  " got idx %0d n (%0d %0d %0d) has %0d"},
                                 exp_ans.idx, exp_ans.nx, exp_ans.ny, exp_ans.nz, exp_ans.has,
                                 o_queried_index, o_normal_x, o_normal_y, o_normal_z,
                                 o_has_normal);
                end
            end
        end
        // The long hold-off lets the block fill up and push back on its input.
        if (hold_req && !hold_done) begin
            if (hold_cnt == HOLD_CYCLES) begin
                hold_done <= 1'b1;
                i_stall <= 1'b0;
            end else begin
                hold_cnt <= hold_cnt + 1;
                i_stall <= 1'b1;
            end
        end else begin
            i_stall <= (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("vertex_normal_averager verification failed");
            $finish;
        end
    end

    initial begin
        t_mesh_beat bt;
        t_normal_answer none;
        int pick;
        none = '{default: '0};
        for (int v = 0; v < SLOTS; v++) begin
            count_mirror[v] = 0;
            was_loaded[v] = 0;
        end

        // Directed rows. Typed answers are the obvious ones: nothing after reset, the
        // axis-aligned face whose normal points down z, and a vertex never in a face.
        add_row(vna_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_QUERY, 1023, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_LOAD, 1, 256, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_LOAD, 2, 0, 256, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_TRI, 0, 0, 0, 0, 0, 1, 2, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, -16384, 1);
        // Position extremes give the widest cross product.
        add_row(vna_pkg::KIND_LOAD, 3, 32767, -32768, 32767, 1023, 0, 1023, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_LOAD, 1023, -32768, 32767, -32768, 0, 1023, 0, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_LOAD, 4, -32768, -32768, -32768, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_TRI, 0, -1, -1, -1, 3, 1023, 4, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_QUERY, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_QUERY, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // Degenerate face: all corners the same vertex, zero normal, three updates.
        add_row(vna_pkg::KIND_TRI, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // Repeated corner updates that vertex twice.
        add_row(vna_pkg::KIND_TRI, 0, 0, 0, 0, 1, 2, 1, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_QUERY, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_QUERY, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // The spare kind must do nothing at all.
        add_row(KIND_SPARE, 1, 100, 100, 100, 0, 1, 2, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_QUERY, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // Overwriting a position changes the next face.
        add_row(vna_pkg::KIND_LOAD, 1, 0, 0, 512, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_TRI, 0, 0, 0, 0, 2, 0, 1, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_QUERY, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        // Loaded but never in a face.
        add_row(vna_pkg::KIND_LOAD, 500, 7, 7, 7, 0, 0, 0, 0, 0, 0, 0, 0);
        add_row(vna_pkg::KIND_QUERY, 500, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stimulus_table[r])
            offer_beat(stimulus_table[r].beat, stimulus_table[r].typed,
                       stimulus_table[r].answer);

        // Count saturation: one real face, then degenerate faces on the same vertex
        // until its count has long stuck at 255 and the mean has decayed.
        bt = make_beat(vna_pkg::KIND_LOAD, 600, -1000, 3000, 20000, 0, 0, 0);
        offer_beat(bt, 0, none);
        bt = make_beat(vna_pkg::KIND_TRI, 0, 0, 0, 0, 600, 2, 4);
        offer_beat(bt, 0, none);
        for (int k = 0; k < 95; k++) begin
            bt = make_beat(vna_pkg::KIND_TRI, 0, 0, 0, 0, 600, 600, 600);
            offer_beat(bt, 0, none);
            if (k % 20 == 0 || k > 80) begin
                bt = make_beat(vna_pkg::KIND_QUERY, 600, 0, 0, 0, 0, 0, 0);
                offer_beat(bt, 0, none);
            end
        end

        // Random mesh traffic in three idling phases.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 3) begin
                tx_idle_pct = 62;
                rx_idle_pct = 28;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
                hold_req <= 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                bt = noise_beat(vna_pkg::KIND_LOAD);
                if ($urandom_range(0, 1)) bt.vidx = 10'($urandom_range(0, 15));
                bt.px = pick_coord();
                bt.py = pick_coord();
                bt.pz = pick_coord();
            end else if (pick < 62) begin
                bt = noise_beat(vna_pkg::KIND_TRI);
                bt.ta = pick_corner();
                bt.tb = pick_corner();
                bt.tc = pick_corner();
            end else if (pick < 95) begin
                bt = noise_beat(vna_pkg::KIND_QUERY);
                if ($urandom_range(0, 9) < 7) bt.vidx = pick_corner();
            end else begin
                bt = noise_beat(KIND_SPARE);
            end
            offer_beat(bt, 0, none);
        end
        i_valid <= 1'b0;

        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0 && pending_answers.size() == 0) begin
            $display("vertex_normal_averager verification clean");
        end else begin
            $display("vertex_normal_averager verification failed");
        end
        $finish;
    end

endmodule
